[design/tcce_pkg.sv]
// Package for the text console cursor engine.
// Holds field widths, character codes, opcodes and the result record.
// No dependencies.
package tcce_pkg;

  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;

  localparam int OPCODE_W = 1;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PRINT = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef struct packed {
    logic              write_valid;
    logic [ROW_W-1:0]  write_row;
    logic [COL_W-1:0]  write_col;
    logic [CHAR_W-1:0] write_char;
    logic [ATTR_W-1:0] write_attr;
    logic              scroll_up;
    logic              clear_all;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } result_t;

endpackage

[design/tcce_in_if.sv]
// Input channel of the text console cursor engine: valid/ready plus one item.
// Depends on tcce_pkg.
interface tcce_in_if import tcce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CHAR_W-1:0] character;

  modport source (output valid, output opcode, output character, input ready);
  modport sink   (input valid, input opcode, input character, output ready);
endinterface

[design/tcce_out_if.sv]
// Result channel of the text console cursor engine: valid/ready plus one item.
// Depends on tcce_pkg.
interface tcce_out_if import tcce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              write_valid;
  logic [ROW_W-1:0]  write_row;
  logic [COL_W-1:0]  write_col;
  logic [CHAR_W-1:0] write_char;
  logic [ATTR_W-1:0] write_attr;
  logic              scroll_up;
  logic              clear_all;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;

  modport source (
    output valid, output write_valid, output write_row, output write_col,
    output write_char, output write_attr, output scroll_up, output clear_all,
    output cursor_row, output cursor_col, input ready
  );
  modport sink (
    input valid, input write_valid, input write_row, input write_col,
    input write_char, input write_attr, input scroll_up, input clear_all,
    input cursor_row, input cursor_col, output ready
  );
endinterface

[design/tcce_step.sv]
// Cursor update for one item: next cursor position and the result record.
// Depends on tcce_pkg.
module tcce_step import tcce_pkg::*; #(
  parameter int COLUMNS = DEFAULT_COLUMNS,
  parameter int ROWS    = DEFAULT_ROWS,
  localparam int RowW   = $clog2(ROWS),
  localparam int ColW   = $clog2(COLUMNS)
) (
  input  opcode_t           opcode,
  input  logic [CHAR_W-1:0] character,
  input  logic [ATTR_W-1:0] attr,
  input  logic [RowW-1:0]   row,
  input  logic [ColW-1:0]   col,
  output logic [RowW-1:0]   row_next,
  output logic [ColW-1:0]   col_next,
  output result_t           result
);

  localparam logic [RowW-1:0] RowLast = RowW'(ROWS - 1);
  localparam logic [ColW-1:0] ColLast = ColW'(COLUMNS - 1);

  logic            row_last;
  logic            col_last;
  logic            wv;
  logic [RowW-1:0] wr;
  logic [ColW-1:0] wc;
  logic [CHAR_W-1:0] wch;
  logic            scroll;
  logic            clr;

  assign row_last = (row == RowLast);
  assign col_last = (col == ColLast);

  always_comb begin
    row_next = row;
    col_next = col;
    wv       = 1'b0;
    wr       = '0;
    wc       = '0;
    wch      = '0;
    scroll   = 1'b0;
    clr      = 1'b0;
    if (opcode == OP_CLEAR) begin
      row_next = '0;
      col_next = '0;
      clr      = 1'b1;
    end else begin
      unique case (character)
        CHAR_NEWLINE: begin
          col_next = '0;
          if (row_last) scroll = 1'b1;
          else row_next = row + RowW'(1);
        end
        CHAR_RETURN: begin
          col_next = '0;
        end
        CHAR_BACKSPACE: begin
          if (col != '0) begin
            col_next = col - ColW'(1);
            wv       = 1'b1;
            wr       = row;
            wc       = col - ColW'(1);
            wch      = CHAR_SPACE;
          end else if (row != '0) begin
            row_next = row - RowW'(1);
            col_next = ColLast;
            wv       = 1'b1;
            wr       = row - RowW'(1);
            wc       = ColLast;
            wch      = CHAR_SPACE;
          end
        end
        default: begin
          wv  = 1'b1;
          wr  = row;
          wc  = col;
          wch = character;
          if (col_last) begin
            col_next = '0;
            if (row_last) scroll = 1'b1;
            else row_next = row + RowW'(1);
          end else begin
            col_next = col + ColW'(1);
          end
        end
      endcase
    end
  end

  always_comb begin
    result.write_valid = wv;
    result.write_row   = ROW_W'(wr);
    result.write_col   = COL_W'(wc);
    result.write_char  = wch;
    result.write_attr  = attr;
    result.scroll_up   = scroll;
    result.clear_all   = clr;
    result.cursor_row  = ROW_W'(row_next);
    result.cursor_col  = COL_W'(col_next);
  end

endmodule

[design/text_console_cursor_engine_core.sv]
// Text console cursor engine, top level. Takes one item per cycle (print a
// character or clear the screen) while the output side is ready, keeps the
// cursor and emits one result per item: the cell written, scroll and clear
// requests and the new cursor. An item passes an input register, then the
// cursor update and the result register; with the output side ready a new
// item is accepted every cycle, the cursor register being updated in the
// same cycle the result is registered. Depends on tcce_pkg, tcce_in_if,
// tcce_out_if and tcce_step.
module text_console_cursor_engine_core import tcce_pkg::*; #(
  parameter int COLUMNS = DEFAULT_COLUMNS,
  parameter int ROWS    = DEFAULT_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  tcce_in_if.sink           in_ch,
  tcce_out_if.source        out_ch,
  input  logic              cfg_write_enable,
  input  logic [ATTR_W-1:0] cfg_write_data
);

  localparam int RowW = $clog2(ROWS);
  localparam int ColW = $clog2(COLUMNS);

  logic              s1_valid;
  opcode_t           s1_opcode;
  logic [CHAR_W-1:0] s1_char;

  logic              o_valid;
  result_t           o_result;

  logic [ATTR_W-1:0] attr;
  logic [RowW-1:0]   row;
  logic [ColW-1:0]   col;
  logic [RowW-1:0]   row_next;
  logic [ColW-1:0]   col_next;
  result_t           step_result;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free    = !o_valid || out_ch.ready;
  assign s1_fire     = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_write_enable) begin
      attr <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode <= opcode_t'(in_ch.opcode);
      s1_char   <= in_ch.character;
    end
  end

  tcce_step #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_step (
    .opcode    (s1_opcode),
    .character (s1_char),
    .attr      (attr),
    .row       (row),
    .col       (col),
    .row_next  (row_next),
    .col_next  (col_next),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      col     <= '0;
      o_valid <= 1'b0;
    end else begin
      if (s1_fire) begin
        row <= row_next;
        col <= col_next;
      end
      if (out_free) begin
        o_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      o_result <= step_result;
    end
  end

  assign out_ch.valid       = o_valid;
  assign out_ch.write_valid = o_result.write_valid;
  assign out_ch.write_row   = o_result.write_row;
  assign out_ch.write_col   = o_result.write_col;
  assign out_ch.write_char  = o_result.write_char;
  assign out_ch.write_attr  = o_result.write_attr;
  assign out_ch.scroll_up   = o_result.scroll_up;
  assign out_ch.clear_all   = o_result.clear_all;
  assign out_ch.cursor_row  = o_result.cursor_row;
  assign out_ch.cursor_col  = o_result.cursor_col;

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (row <= RowW'(ROWS - 1)) && (col <= ColW'(COLUMNS - 1)))
    else $error("cursor outside the screen");

  a_clear_homes: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_result.clear_all |->
      !o_result.write_valid && !o_result.scroll_up &&
      (o_result.cursor_row == '0) && (o_result.cursor_col == '0))
    else $error("clear result not at home position");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_char) && $stable(s1_opcode))
    else $error("stalled item lost from input register");

  a_scroll_last_row: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_result.scroll_up |->
      (o_result.cursor_row == ROW_W'(ROWS - 1)) && (o_result.cursor_col == '0))
    else $error("scroll without cursor at start of last row");

endmodule
